// ----- design/assert_macros.svh -----
// Assertion macros shared by the timer table RTL.
// Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// ante in one cycle implies cons in the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- design/stt_pkg.sv -----
// Types and codes for the software timer table.
// No dependencies.
package stt_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_KILL = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] TT_ONESHOT  = 2'd0;
  localparam logic [1:0] TT_PERIODIC = 2'd1;
  localparam logic [1:0] TT_MAX      = 2'd2;
  localparam logic [1:0] TT_MIN      = 2'd3;

  localparam logic [2:0] K_EXPIRED  = 3'd0;
  localparam logic [2:0] K_SET_OK   = 3'd1;
  localparam logic [2:0] K_SET_FULL = 3'd2;
  localparam logic [2:0] K_KILLED   = 3'd3;
  localparam logic [2:0] K_NO_KILL  = 3'd4;
  localparam logic [2:0] K_NO_EXP   = 3'd5;

  localparam int RESULT_CAP = 16;
  localparam int NW = $clog2(RESULT_CAP + 1);

  localparam logic signed [31:0] MS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] MS_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [7:0]         owner;
    logic [7:0]         cmd;
    logic [15:0]        arg_one;
    logic [15:0]        arg_two;
    logic               repeats;
    logic signed [31:0] period_ms;
    logic signed [31:0] rem_ms;
  } slot_rec_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  obj;
    logic [7:0]  cmd;
    logic [15:0] first;
    logic [15:0] second;
    logic [3:0]  slot;
    logic        last;
  } result_t;

endpackage

// ----- design/stt_in_if.sv -----
// Request channel of the timer table: valid/ready plus request fields.
// No dependencies.
interface stt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [30:0] amount_ms;
  logic [7:0]  object_id;
  logic [7:0]  command;
  logic [1:0]  timer_type;
  logic signed [15:0] first_param;
  logic signed [15:0] second_param;

  modport source (output valid, operation, amount_ms, object_id, command, timer_type,
                  first_param, second_param, input ready);
  modport sink (input valid, operation, amount_ms, object_id, command, timer_type,
                first_param, second_param, output ready);
endinterface

// ----- design/stt_out_if.sv -----
// Result channel of the timer table: valid/ready plus result fields.
// No dependencies.
interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_object;
  logic [7:0]  out_command;
  logic signed [15:0] out_first;
  logic signed [15:0] out_second;
  logic [3:0]  slot;
  logic        last;

  modport source (output valid, kind, out_object, out_command, out_first, out_second,
                  slot, last, input ready);
  modport sink (input valid, kind, out_object, out_command, out_first, out_second,
                slot, last, output ready);
endinterface

// ----- design/software_timer_table.sv -----
// Software timer table: ring of NUM_TIMERS slot cells rotating past one head unit.
// Sequence: tick and kill make one scan pass of the ring, set a find pass, then a write
// pass (no write pass when rejected); each then flushes its result, and output stalls
// can hold it. Opcode 3 posts no result.
// Throughput: one request at a time; the ring rotates one slot per cycle unless stalled.
// Reset (rst, synchronous): all slots free, no result pending.
// Depends on stt_pkg, stt_in_if, stt_out_if, stt_cell, assert_macros.svh.
`include "assert_macros.svh"
module software_timer_table #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  stt_in_if.sink      req,
  stt_out_if.source   rsp
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t st;

  logic [1:0]  op;
  logic [30:0] amount;
  logic [7:0]  obj;
  logic [7:0]  cmd;
  logic [1:0]  ttype;
  logic [15:0] p1;
  logic [15:0] p2;
  logic signed [31:0] ms1;

  logic [CW-1:0] cnt;
  logic [IW-1:0] idx;
  logic [stt_pkg::NW-1:0] n;
  logic          matched;
  logic          chosen_v;
  logic [IW-1:0] chosen;

  stt_pkg::result_t pend;
  logic             pend_v;
  stt_pkg::result_t out_r;
  logic             out_valid;

  stt_pkg::slot_rec_t ring [NUM_TIMERS];
  stt_pkg::slot_rec_t link [NUM_TIMERS];
  stt_pkg::slot_rec_t head;
  stt_pkg::slot_rec_t head_next;

  logic               live, key_hit, expire, emit, stall, shift, out_free, last_step;
  logic               set_pick, out_load;
  logic signed [32:0] sub;
  logic signed [31:0] sub_c;
  logic signed [32:0] add;
  logic signed [31:0] add_c;
  stt_pkg::result_t   exp_res;
  stt_pkg::result_t   fin_res;
  stt_pkg::result_t   load_res;

  // ring: cell 0 is the head, the processed record re-enters at the tail
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    if (g == NUM_TIMERS - 1) begin : g_tail
      assign link[g] = head_next;
    end else begin : g_mid
      assign link[g] = ring[g+1];
    end
    stt_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(link[g]), .rec(ring[g]));
  end

  assign head      = ring[0];
  assign idx       = cnt[IW-1:0];
  assign out_free  = !out_valid || rsp.ready;
  assign last_step = (cnt == CW'(NUM_TIMERS - 1));
  assign live      = (head.owner != 8'd0);
  assign key_hit   = (obj != 8'd0) && (head.owner == obj) && (head.cmd == cmd);
  assign set_pick  = (obj != 8'd0) && !matched && (key_hit || !live);

  always_comb begin
    sub = {head.rem_ms[31], head.rem_ms} - $signed({2'b00, amount});
    sub_c = (sub[32] != sub[31]) ? stt_pkg::MS_MIN : sub[31:0];
    add = {sub_c[31], sub_c} + {head.period_ms[31], head.period_ms};
    if (add[32] != add[31]) begin
      add_c = add[32] ? stt_pkg::MS_MIN : stt_pkg::MS_MAX;
    end else begin
      add_c = add[31:0];
    end
  end

  always_comb begin
    head_next = head;
    expire    = 1'b0;
    unique case (st)
      S_SCAN: begin
        if (op == stt_pkg::OP_TICK && live) begin
          head_next.rem_ms = sub_c;
          if (sub_c[31] || sub_c == 32'sd0) begin
            expire = 1'b1;
            if (head.repeats) begin
              head_next.rem_ms = add_c;
            end else begin
              head_next.owner = 8'd0;
            end
          end
        end else if (op == stt_pkg::OP_KILL && key_hit && !matched) begin
          head_next.owner = 8'd0;
        end
      end
      S_WRITE: begin
        if (idx == chosen) begin
          head_next.owner     = obj;
          head_next.cmd       = cmd;
          head_next.arg_one   = p1;
          head_next.arg_two   = p2;
          head_next.repeats   = (ttype == stt_pkg::TT_PERIODIC);
          head_next.period_ms = ms1;
          head_next.rem_ms    = ms1;
        end
      end
      default: begin
      end
    endcase
  end

  assign emit  = expire && (n < stt_pkg::NW'(stt_pkg::RESULT_CAP));
  assign stall = emit && pend_v && !out_free;
  assign shift = (st == S_SCAN || st == S_WRITE) && !stall;

  always_comb begin
    exp_res        = '0;
    exp_res.kind   = stt_pkg::K_EXPIRED;
    exp_res.obj    = head.owner;
    exp_res.cmd    = head.cmd;
    exp_res.first  = head.arg_one;
    exp_res.second = head.arg_two;
    exp_res.slot   = 4'(idx);
  end

  always_comb begin
    fin_res      = '0;
    fin_res.last = 1'b1;
    fin_res.obj  = obj;
    fin_res.cmd  = cmd;
    unique case (op)
      stt_pkg::OP_TICK: begin
        if (pend_v) begin
          fin_res      = pend;
          fin_res.last = 1'b1;
        end else begin
          fin_res.kind = stt_pkg::K_NO_EXP;
          fin_res.obj  = 8'd0;
          fin_res.cmd  = 8'd0;
        end
      end
      stt_pkg::OP_SET: begin
        fin_res.kind = chosen_v ? stt_pkg::K_SET_OK : stt_pkg::K_SET_FULL;
        fin_res.slot = chosen_v ? 4'(chosen) : 4'd0;
      end
      stt_pkg::OP_KILL: begin
        fin_res.kind = matched ? stt_pkg::K_KILLED : stt_pkg::K_NO_KILL;
        fin_res.slot = matched ? 4'(chosen) : 4'd0;
      end
      default: begin
        fin_res.kind = stt_pkg::K_NO_EXP;
      end
    endcase
  end

  // earlier expiry leaves when a newer one arrives; the final one goes out at flush
  assign out_load = (shift && emit && pend_v) || (st == S_FLUSH && out_free);
  assign load_res = (st == S_FLUSH) ? fin_res : pend;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= load_res;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      cnt      <= '0;
      n        <= '0;
      pend_v   <= 1'b0;
      matched  <= 1'b0;
      chosen_v <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (req.valid) begin
            op       <= req.operation;
            amount   <= req.amount_ms;
            obj      <= req.object_id;
            cmd      <= req.command;
            ttype    <= req.timer_type;
            p1       <= req.first_param;
            p2       <= req.second_param;
            ms1      <= $signed({1'b0, req.amount_ms});
            cnt      <= '0;
            n        <= '0;
            pend_v   <= 1'b0;
            matched  <= 1'b0;
            chosen_v <= 1'b0;
            st       <= (req.operation == stt_pkg::OP_NONE) ? S_IDLE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (shift) begin
            if (op == stt_pkg::OP_TICK && emit) begin
              pend   <= exp_res;
              pend_v <= 1'b1;
              n      <= n + 1'b1;
            end
            if (op == stt_pkg::OP_KILL && key_hit && !matched) begin
              matched <= 1'b1;
              chosen  <= idx;
            end
            if (op == stt_pkg::OP_SET && set_pick) begin
              chosen   <= idx;
              chosen_v <= 1'b1;
              if (key_hit) begin
                matched <= 1'b1;
                if ((ttype == stt_pkg::TT_MAX && head.rem_ms > ms1) ||
                    (ttype == stt_pkg::TT_MIN && head.rem_ms < ms1)) begin
                  ms1 <= head.rem_ms;
                end
              end
            end
            if (last_step) begin
              cnt <= '0;
              st  <= (op == stt_pkg::OP_SET && (chosen_v || set_pick)) ? S_WRITE : S_FLUSH;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_WRITE: begin
          if (last_step) begin
            cnt <= '0;
            st  <= S_FLUSH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            pend_v <= 1'b0;
            st     <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (st == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_r.kind;
  assign rsp.out_object  = out_r.obj;
  assign rsp.out_command = out_r.cmd;
  assign rsp.out_first   = out_r.first;
  assign rsp.out_second  = out_r.second;
  assign rsp.slot        = out_r.slot;
  assign rsp.last        = out_r.last;

  `ASSERT_ALWAYS(a_pend_tick, clk, rst,
    !pend_v || (op == stt_pkg::OP_TICK && (st == S_SCAN || st == S_FLUSH)),
    "pending expiry outside a tick")
  `ASSERT_ALWAYS(a_cap, clk, rst, n <= stt_pkg::NW'(stt_pkg::RESULT_CAP),
    "expiry count past cap")
  `ASSERT_NEXT(a_flush_done, clk, rst, st == S_FLUSH && out_free,
    st == S_IDLE && out_valid && rsp.last, "flush did not post final word")
  `ASSERT_ALWAYS(a_cnt_range, clk, rst, cnt < CW'(NUM_TIMERS), "slot counter out of range")
  `ASSERT_ALWAYS(a_write_ok, clk, rst, st != S_WRITE || (chosen_v && op == stt_pkg::OP_SET),
    "write pass without a chosen slot")

endmodule

// ----- design/stt_cell.sv -----
// One timer slot of the ring: holds a slot record, takes its neighbor's on shift.
// Depends on stt_pkg.
module stt_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  stt_pkg::slot_rec_t d,
  output stt_pkg::slot_rec_t rec
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.owner <= '0;
    end else if (shift) begin
      rec <= d;
    end
  end

endmodule
